### src/twio_pkg.sv
// ----------------------------------------------------------------------------
// twio_pkg
// Shared constants, register map and a helper function of the two-wheel
// IMU odometry block.
// ----------------------------------------------------------------------------
package twio_pkg;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [1:0] REG_WHEEL_RADIUS = 2'd0;
  localparam logic [1:0] REG_HORIZ_OFFSET = 2'd1;
  localparam logic [1:0] REG_VERT_OFFSET  = 2'd2;

  localparam logic [15:0] WHEEL_RADIUS_RST = 16'd1024;

  // Operand widths of the shared multiplier and divider.
  localparam int MUL_A_W = 38;
  localparam int MUL_B_W = 34;
  localparam int NUM_W   = 63;
  localparam int DEN_W   = 50;
  localparam int CNT_W   = 6;

  // pi/18000 in Q40.
  localparam logic signed [MUL_B_W-1:0] RAD_K_Q40 = 34'sd191900981;
  // 1e-3 rad in Q29.
  localparam logic [50:0] SMALL_TURN_Q29 = 51'd536871;
  localparam logic signed [31:0] CORDIC_GAIN_Q29 = 32'sd326016437;
  localparam logic [4:0] CORDIC_LAST = 5'd27;

  localparam logic [15:0]        FULL_TURN_CD = 16'd36000;
  localparam logic signed [16:0] HALF_TURN_CD = 17'sd18000;
  localparam logic signed [16:0] QUARTER_CD   = 17'sd9000;

  // Rounded-up 2^47 / 36000; the quotient of a 33-bit magnitude by a full
  // turn is the product shifted right by 47, exact over the whole range.
  localparam logic signed [MUL_B_W-1:0] RECIP_TURN_Q47 = 34'sd3909374677;

  // The arc radius divider produces one quotient bit per step.
  localparam logic [CNT_W-1:0] DIV_STEPS = 6'd63;

  // Arctangent of 2^-i in Q29.
  function automatic logic signed [31:0] atan_q29(input logic [4:0] i);
    logic signed [31:0] v;
    case (i)
      5'd0:    v = 32'sd421657428;
      5'd1:    v = 32'sd248918915;
      5'd2:    v = 32'sd131521918;
      5'd3:    v = 32'sd66762579;
      5'd4:    v = 32'sd33510843;
      5'd5:    v = 32'sd16771758;
      5'd6:    v = 32'sd8387925;
      5'd7:    v = 32'sd4194219;
      5'd8:    v = 32'sd2097141;
      5'd9:    v = 32'sd1048575;
      default: v = 32'sd1 <<< (5'd29 - i);
    endcase
    return v;
  endfunction

endpackage

### src/two_wheel_imu_odometry.sv
// ----------------------------------------------------------------------------
// two_wheel_imu_odometry
// Takes a new input beat only when idle, so each item is finished before
// the next is accepted. The pace is set by the bit-serial divider (63 steps
// per arc radius), the 28-step CORDIC and the two-multiply angle reduction.
// A result that waits for the output register stalls the input.
// Reset (rst_ni low, asynchronous) clears the pose, heading and previous
// sample, and loads wheel_radius = 1024 and both offsets = 0.
// ----------------------------------------------------------------------------
module two_wheel_imu_odometry (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [31:0]           horiz_angle_i,
  input  logic signed [31:0]           vert_angle_i,
  input  logic signed [31:0]           imu_heading_i,
  input  logic        [31:0]           time_us_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [31:0]           pose_x_out_o,
  output logic signed [31:0]           pose_y_out_o,
  output logic signed [31:0]           heading_out_o,
  output logic        [31:0]           stamp_out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [twio_pkg::ADDR_W-1:0]  paddr,
  input  logic [twio_pkg::DATA_W-1:0]  pwdata,
  output logic [twio_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import twio_pkg::*;

  // Sequencer states. The multiplier is issued in the first block of states
  // and also reduces each heading modulo a full turn by a reciprocal product,
  // the shared divider forms the arc radii, and the CORDIC shift-add unit
  // runs once or twice per item.
  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_MH   = 5'd1;
  localparam logic [4:0] ST_MV   = 5'd2;
  localparam logic [4:0] ST_MT   = 5'd3;
  localparam logic [4:0] ST_RH   = 5'd4;
  localparam logic [4:0] ST_RV   = 5'd5;
  localparam logic [4:0] ST_DV   = 5'd6;
  localparam logic [4:0] ST_MQ   = 5'd7;
  localparam logic [4:0] ST_FOLD = 5'd8;
  localparam logic [4:0] ST_ZLD  = 5'd9;
  localparam logic [4:0] ST_CORD = 5'd10;
  localparam logic [4:0] ST_CEND = 5'd11;
  localparam logic [4:0] ST_DIV  = 5'd12;
  localparam logic [4:0] ST_DEND = 5'd13;
  localparam logic [4:0] ST_T0   = 5'd14;
  localparam logic [4:0] ST_T1   = 5'd15;
  localparam logic [4:0] ST_T2   = 5'd16;
  localparam logic [4:0] ST_T3   = 5'd17;
  localparam logic [4:0] ST_T4   = 5'd18;
  localparam logic [4:0] ST_WB   = 5'd19;
  localparam logic [4:0] ST_MR   = 5'd20;

  // Control and architectural state.
  logic [4:0]         state_q;
  logic               pass_q;
  logic               div_sel_q;
  logic [CNT_W-1:0]   div_cnt_q;
  logic [4:0]         it_q;
  logic               out_valid_q;
  logic [15:0]        wheel_radius_q;
  logic signed [15:0] horiz_offset_q;
  logic signed [15:0] vert_offset_q;
  logic signed [31:0] prev_horiz_q;
  logic signed [31:0] prev_vert_q;
  logic signed [31:0] prev_heading_q;
  logic signed [31:0] pose_x_q;
  logic signed [31:0] pose_y_q;
  logic signed [31:0] heading_total_q;

  // Datapath registers.
  logic signed [31:0] h_q, v_q, hd_q;
  logic        [31:0] tm_q;
  logic signed [63:0] prod_q;
  logic signed [37:0] rad_h_q, rad_v_q;
  logic signed [50:0] dth_q;
  logic signed [33:0] pa_q, qa_q;
  logic [DEN_W-1:0]   div_rem_q;
  logic [NUM_W-1:0]   div_num_q;
  logic [DEN_W-1:0]   div_den_q;
  logic               q_neg_q;
  logic               neg_q;
  logic signed [31:0] x_q, y_q, z_q;
  logic signed [31:0] cl_q, sl_q, cc_q, sc_q;
  logic signed [63:0] acc_q;
  logic signed [35:0] dx_q, dy_q;
  logic signed [31:0] out_x_q, out_y_q, out_hd_q;
  logic        [31:0] out_tm_q;

  // Combinational signals.
  logic signed [32:0] dang_h, dang_v, dcd, last_cd, cur_cd, ang;
  logic        [32:0] last_mag, cur_mag, ang_mag, mod_rem;
  logic        [16:0] mod_quo;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [71:0] mul_full;
  logic               mul_en;
  logic signed [63:0] rnd24, rnd11, rnd8;
  logic signed [55:0] d56;
  logic signed [33:0] dist_n;
  logic signed [64:0] sum65;
  logic signed [35:0] d_n;
  logic [51:0]        div_trial;
  logic [DEN_W-1:0]   div_rem_n;
  logic [15:0]        rem16;
  logic signed [16:0] r0, r1, r_fold;
  logic               neg_fold;
  logic signed [31:0] xs, ys, at;
  logic signed [31:0] cos_v, sin_v;
  logic signed [50:0] dth_mag_s;
  logic               small_turn;
  logic signed [33:0] div_x;
  logic signed [33:0] div_x_mag;
  logic signed [63:0] quot_s, off_s, rdiff;
  logic signed [33:0] r_clamp;
  logic signed [32:0] ux, uy, b0, b1, b2, b3;
  logic signed [36:0] px_sum, py_sum;
  logic signed [31:0] px_sat, py_sat;
  logic               in_acc;
  logic               cfg_wr;
  logic               out_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign cfg_wr     = psel && penable && pwrite;
  assign pready     = 1'b1;
  assign out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign pose_x_out_o  = out_x_q;
  assign pose_y_out_o  = out_y_q;
  assign heading_out_o = out_hd_q;
  assign stamp_out_o   = out_tm_q;

  always_comb begin
    case (paddr[3:2])
      REG_WHEEL_RADIUS: prdata = {16'd0, wheel_radius_q};
      REG_HORIZ_OFFSET: prdata = 32'(horiz_offset_q);
      REG_VERT_OFFSET:  prdata = 32'(vert_offset_q);
      default:          prdata = '0;
    endcase
  end

  // Angle differences are exact in 33 bits. The IMU heading is negated so
  // that counter-clockwise is positive.
  assign dang_h   = 33'(h_q) - 33'(prev_horiz_q);
  assign dang_v   = 33'(v_q) - 33'(prev_vert_q);
  assign last_cd  = 33'sd0 - 33'(prev_heading_q);
  assign cur_cd   = 33'sd0 - 33'(hd_q);
  assign dcd      = 33'(prev_heading_q) - 33'(hd_q);
  assign ang      = pass_q ? cur_cd : last_cd;
  assign last_mag = last_cd[32] ? 33'(-last_cd) : 33'(last_cd);
  assign cur_mag  = cur_cd[32] ? 33'(-cur_cd) : 33'(cur_cd);
  assign ang_mag  = pass_q ? cur_mag : last_mag;

  // Rounding of the registered product for each use.
  assign rnd24  = prod_q + (64'sd1 <<< 23);
  assign rnd11  = prod_q + 64'sd1024;
  assign rnd8   = prod_q + 64'sd128;
  assign d56    = rnd8[63:8];
  always_comb begin
    if (d56 > 56'sd4294967296) begin
      dist_n = 34'sd4294967296;
    end else if (d56 < -56'sd4294967296) begin
      dist_n = -34'sd4294967296;
    end else begin
      dist_n = d56[33:0];
    end
  end
  assign sum65 = 65'(acc_q) + 65'(prod_q) + (65'sd1 <<< 28);
  assign d_n   = sum65[64:29];

  // Turn test on the heading change.
  assign dth_mag_s  = dth_q[50] ? -dth_q : dth_q;
  assign small_turn = $unsigned(dth_mag_s) < SMALL_TURN_Q29;

  // Shared divider step: restoring, one quotient bit per cycle.
  assign div_trial = {1'b0, div_rem_q, div_num_q[NUM_W-1]} - {2'b00, div_den_q};
  assign div_rem_n = div_trial[51] ? {div_rem_q[DEN_W-2:0], div_num_q[NUM_W-1]}
                                   : div_trial[DEN_W-1:0];

  // The heading magnitude modulo a full turn: the first product gives the
  // quotient, the second gives quotient times a full turn, and the
  // difference is the remainder. No correction is needed.
  assign mod_quo = prod_q[63:47];
  assign mod_rem = ang_mag - prod_q[32:0];
  assign rem16   = mod_rem[15:0];

  // Reduce the angle into [-9000, 9000] hundredths of degree, folding by a
  // half turn when needed, in which case both CORDIC outputs are negated.
  always_comb begin
    if (ang[32] && (rem16 != 16'd0)) begin
      r0 = $signed({1'b0, FULL_TURN_CD}) - $signed({1'b0, rem16});
    end else begin
      r0 = $signed({1'b0, rem16});
    end
    if (r0 >= HALF_TURN_CD) begin
      r1 = r0 - $signed({1'b0, FULL_TURN_CD});
    end else begin
      r1 = r0;
    end
    if (r1 > QUARTER_CD) begin
      r_fold   = r1 - HALF_TURN_CD;
      neg_fold = 1'b1;
    end else if (r1 < -QUARTER_CD) begin
      r_fold   = r1 + HALF_TURN_CD;
      neg_fold = 1'b1;
    end else begin
      r_fold   = r1;
      neg_fold = 1'b0;
    end
  end

  // CORDIC micro-rotation.
  assign xs    = x_q >>> it_q;
  assign ys    = y_q >>> it_q;
  assign at    = atan_q29(it_q);
  assign cos_v = neg_q ? -x_q : x_q;
  assign sin_v = neg_q ? -y_q : y_q;

  // Arc radius from the divider result: signed quotient minus the offset.
  assign div_x     = div_sel_q ? qa_q : pa_q;
  assign div_x_mag = div_x[33] ? -div_x : div_x;
  assign quot_s    = q_neg_q ? -$signed({1'b0, div_num_q}) : $signed({1'b0, div_num_q});
  assign off_s     = (div_sel_q ? 64'(vert_offset_q) : 64'(horiz_offset_q)) <<< 8;
  assign rdiff     = quot_s - off_s;
  always_comb begin
    if (rdiff > 64'sd2147483648) begin
      r_clamp = 34'sd2147483648;
    end else if (rdiff < -64'sd2147483648) begin
      r_clamp = -34'sd2147483648;
    end else begin
      r_clamp = rdiff[33:0];
    end
  end

  // Second operands of the four rotation products. A small turn rotates the
  // wheel distances by the previous heading; a larger one scales the change
  // of the unit heading vector by the arc radii.
  assign ux = 33'(cc_q) - 33'(cl_q);
  assign uy = 33'(sc_q) - 33'(sl_q);
  always_comb begin
    if (small_turn) begin
      b0 = 33'(cl_q);
      b1 = -33'(sl_q);
      b2 = 33'(sl_q);
      b3 = 33'(cl_q);
    end else begin
      b0 = uy;
      b1 = ux;
      b2 = -ux;
      b3 = uy;
    end
  end

  // Shared multiplier operand select; the product is registered.
  always_comb begin
    mul_en = 1'b1;
    case (state_q)
      ST_MH: begin
        mul_a = MUL_A_W'(dang_h);
        mul_b = RAD_K_Q40;
      end
      ST_MV: begin
        mul_a = MUL_A_W'(dang_v);
        mul_b = RAD_K_Q40;
      end
      ST_MT: begin
        mul_a = MUL_A_W'(dcd);
        mul_b = RAD_K_Q40;
      end
      ST_RH: begin
        mul_a = rad_h_q;
        mul_b = $signed({18'd0, wheel_radius_q});
      end
      ST_RV: begin
        mul_a = rad_v_q;
        mul_b = $signed({18'd0, wheel_radius_q});
      end
      ST_MQ: begin
        mul_a = $signed({5'd0, ang_mag});
        mul_b = RECIP_TURN_Q47;
      end
      ST_MR: begin
        mul_a = $signed({21'd0, mod_quo});
        mul_b = $signed({18'd0, FULL_TURN_CD});
      end
      ST_FOLD: begin
        mul_a = MUL_A_W'(r_fold);
        mul_b = RAD_K_Q40;
      end
      ST_T0: begin
        mul_a = MUL_A_W'(pa_q);
        mul_b = MUL_B_W'(b0);
      end
      ST_T1: begin
        mul_a = MUL_A_W'(qa_q);
        mul_b = MUL_B_W'(b1);
      end
      ST_T2: begin
        mul_a = MUL_A_W'(pa_q);
        mul_b = MUL_B_W'(b2);
      end
      ST_T3: begin
        mul_a = MUL_A_W'(qa_q);
        mul_b = MUL_B_W'(b3);
      end
      default: begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
      end
    endcase
  end
  assign mul_full = mul_a * mul_b;

  // Saturating pose update.
  assign px_sum = 37'(pose_x_q) + 37'(dx_q);
  assign py_sum = 37'(pose_y_q) + 37'(dy_q);
  always_comb begin
    if (px_sum > 37'sd2147483647) begin
      px_sat = 32'sh7fffffff;
    end else if (px_sum < -37'sd2147483648) begin
      px_sat = 32'sh80000000;
    end else begin
      px_sat = px_sum[31:0];
    end
    if (py_sum > 37'sd2147483647) begin
      py_sat = 32'sh7fffffff;
    end else if (py_sum < -37'sd2147483648) begin
      py_sat = 32'sh80000000;
    end else begin
      py_sat = py_sum[31:0];
    end
  end

  // Sequencer, configuration and the odometry state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      pass_q          <= 1'b0;
      div_sel_q       <= 1'b0;
      div_cnt_q       <= '0;
      it_q            <= '0;
      out_valid_q     <= 1'b0;
      wheel_radius_q  <= WHEEL_RADIUS_RST;
      horiz_offset_q  <= '0;
      vert_offset_q   <= '0;
      prev_horiz_q    <= '0;
      prev_vert_q     <= '0;
      prev_heading_q  <= '0;
      pose_x_q        <= '0;
      pose_y_q        <= '0;
      heading_total_q <= '0;
    end else begin
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_WHEEL_RADIUS: wheel_radius_q <= pwdata[15:0];
          REG_HORIZ_OFFSET: horiz_offset_q <= $signed(pwdata[15:0]);
          REG_VERT_OFFSET:  vert_offset_q  <= $signed(pwdata[15:0]);
          default: ;
        endcase
      end
      // The write-back state loads a new beat itself, so the plain drain
      // of the output register applies elsewhere.
      if (out_valid_q && out_ready_i && (state_q != ST_WB)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= ST_MH;
          end
        end
        ST_MH: state_q <= ST_MV;
        ST_MV: state_q <= ST_MT;
        ST_MT: state_q <= ST_RH;
        ST_RH: state_q <= ST_RV;
        ST_RV: state_q <= ST_DV;
        ST_DV: begin
          pass_q    <= 1'b0;
          div_sel_q <= 1'b0;
          state_q   <= ST_MQ;
        end
        ST_MQ:   state_q <= ST_MR;
        ST_MR:   state_q <= ST_FOLD;
        ST_FOLD: state_q <= ST_ZLD;
        ST_ZLD: begin
          it_q    <= '0;
          state_q <= ST_CORD;
        end
        ST_CORD: begin
          it_q <= it_q + 1'b1;
          if (it_q == CORDIC_LAST) begin
            state_q <= ST_CEND;
          end
        end
        ST_CEND: begin
          if (pass_q) begin
            div_sel_q <= 1'b0;
            div_cnt_q <= DIV_STEPS;
            state_q   <= ST_DIV;
          end else if (small_turn) begin
            state_q <= ST_T0;
          end else begin
            pass_q  <= 1'b1;
            state_q <= ST_MQ;
          end
        end
        ST_DIV: begin
          div_cnt_q <= div_cnt_q - 1'b1;
          if (div_cnt_q == 6'd1) begin
            state_q <= ST_DEND;
          end
        end
        ST_DEND: begin
          if (div_sel_q) begin
            state_q <= ST_T0;
          end else begin
            div_sel_q <= 1'b1;
            div_cnt_q <= DIV_STEPS;
            state_q   <= ST_DIV;
          end
        end
        ST_T0: state_q <= ST_T1;
        ST_T1: state_q <= ST_T2;
        ST_T2: state_q <= ST_T3;
        ST_T3: state_q <= ST_T4;
        ST_T4: state_q <= ST_WB;
        ST_WB: begin
          // The result beat waits here until the output register is free.
          if (out_free) begin
            pose_x_q        <= px_sat;
            pose_y_q        <= py_sat;
            heading_total_q <= heading_total_q + dcd[31:0];
            prev_horiz_q    <= h_q;
            prev_vert_q     <= v_q;
            prev_heading_q  <= hd_q;
            out_valid_q     <= 1'b1;
            state_q         <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      h_q  <= horiz_angle_i;
      v_q  <= vert_angle_i;
      hd_q <= imu_heading_i;
      tm_q <= time_us_i;
    end
    if (mul_en) begin
      prod_q <= mul_full[63:0];
    end
    case (state_q)
      ST_MV: rad_h_q <= rnd24[61:24];
      ST_MT: rad_v_q <= rnd24[61:24];
      ST_RH: dth_q   <= rnd11[61:11];
      ST_RV: pa_q    <= dist_n;
      ST_DV: qa_q    <= dist_n;
      ST_DIV: begin
        div_rem_q <= div_rem_n;
        div_num_q <= {div_num_q[NUM_W-2:0], ~div_trial[51]};
      end
      ST_FOLD: neg_q <= neg_fold;
      ST_ZLD: begin
        z_q <= rnd11[42:11];
        x_q <= CORDIC_GAIN_Q29;
        y_q <= '0;
      end
      ST_CORD: begin
        if (!z_q[31]) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - at;
        end else begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + at;
        end
      end
      ST_CEND: begin
        if (pass_q) begin
          cc_q      <= cos_v;
          sc_q      <= sin_v;
          div_rem_q <= '0;
          div_num_q <= {1'b0, div_x_mag[32:0], 29'd0};
          div_den_q <= dth_mag_s[DEN_W-1:0];
          q_neg_q   <= div_x[33] ^ dth_q[50];
        end else begin
          cl_q <= cos_v;
          sl_q <= sin_v;
        end
      end
      ST_DEND: begin
        if (div_sel_q) begin
          qa_q <= r_clamp;
        end else begin
          pa_q      <= r_clamp;
          div_rem_q <= '0;
          div_num_q <= {1'b0, (qa_q[33] ? 33'(-qa_q) : qa_q[32:0]), 29'd0};
          q_neg_q   <= qa_q[33] ^ dth_q[50];
        end
      end
      ST_T1: acc_q <= prod_q;
      ST_T2: dx_q  <= d_n;
      ST_T3: acc_q <= prod_q;
      ST_T4: dy_q  <= d_n;
      ST_WB: begin
        if (out_free) begin
          out_x_q  <= px_sat;
          out_y_q  <= py_sat;
          out_hd_q <= heading_total_q + dcd[31:0];
          out_tm_q <= tm_q;
        end
      end
      default: ;
    endcase
  end

endmodule
